// ----- sv/hsbc_pkg.sv -----
// Shared types, stage records and the gamma table for the hue/brightness to LED compare block.
package hsbc_pkg;

	// Request into the block
	typedef struct packed {
		logic       kind;
		logic [2:0] pixel;
		logic [7:0] red_or_hue;
		logic [7:0] green_or_saturation;
		logic [7:0] blue_or_brightness;
	} color_t;

	// Result out of the block
	typedef struct packed {
		logic [2:0] pixel_out;
		logic [7:0] red_compare;
		logic [7:0] green_compare;
		logic [7:0] blue_compare;
	} compare_t;

	// Colour mode codes
	localparam logic KIND_DIRECT = 1'b0;
	localparam logic KIND_HSB    = 1'b1;

	// Hue sector codes
	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;

	// First stage record: raw fields plus products of the first multiplier rank
	typedef struct packed {
		logic       kind;
		logic [2:0] pixel;
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] val;
		logic [2:0] sector;
		logic [7:0] lo;
		logic [7:0] sf_hi;
		logic [7:0] sc_hi;
	} prod_t;

	// Second stage record: channel levels before gamma
	typedef struct packed {
		logic [2:0] pixel;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} level_t;

	localparam logic [7:0] GAMMA [256] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
		8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
		8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,
		8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,   8'd7,   8'd7,
		8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,   8'd10,
		8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,  8'd13,
		8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
		8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
		8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,
		8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,  8'd30,
		8'd31,  8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,
		8'd37,  8'd38,  8'd39,  8'd39,  8'd40,  8'd41,  8'd42,  8'd43,
		8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,  8'd50,
		8'd51,  8'd52,  8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,
		8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd66,  8'd67,  8'd68,
		8'd69,  8'd70,  8'd72,  8'd73,  8'd74,  8'd75,  8'd77,  8'd78,
		8'd79,  8'd81,  8'd82,  8'd83,  8'd85,  8'd86,  8'd87,  8'd89,
		8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,  8'd99,  8'd101,
		8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
		8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
		8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
		8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
		8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
		8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
		8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
		8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
		8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
	};

endpackage

// ----- sv/hsbc_prod.sv -----
// First pipeline stage: hue sector, fraction and the first rank of 8x8 products.
module hsbc_prod (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid,
	input  hsbc_pkg::color_t color,
	output logic             valid_s1,
	output hsbc_pkg::prod_t  prod_s1
);

	logic [10:0] scaled;
	logic [7:0]  frac;
	logic [7:0]  sat_n;
	logic [7:0]  frac_n;
	logic [15:0] lo_full;
	logic [15:0] sf_full;
	logic [15:0] sc_full;

	// Scale hue by six with two shifts and an add, then form the products
	always_comb begin
		scaled  = {1'b0, color.red_or_hue, 2'b00} + {2'b00, color.red_or_hue, 1'b0};
		frac    = scaled[7:0];
		// complement at eight bits: 255 minus the value
		sat_n   = ~color.green_or_saturation;
		frac_n  = ~frac;
		lo_full = color.blue_or_brightness * sat_n;
		sf_full = color.green_or_saturation * frac;
		sc_full = color.green_or_saturation * frac_n;
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1.kind   <= color.kind;
			prod_s1.pixel  <= color.pixel;
			prod_s1.hue    <= color.red_or_hue;
			prod_s1.sat    <= color.green_or_saturation;
			prod_s1.val    <= color.blue_or_brightness;
			prod_s1.sector <= scaled[10:8];
			prod_s1.lo     <= lo_full[15:8];
			prod_s1.sf_hi  <= sf_full[15:8];
			prod_s1.sc_hi  <= sc_full[15:8];
		end
	end

endmodule

// ----- sv/hsbc_mix.sv -----
// Second pipeline stage: falling and rising terms and the per-sector channel mix.
module hsbc_mix (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_s1,
	input  hsbc_pkg::prod_t  prod_s1,
	output logic             valid_s2,
	output hsbc_pkg::level_t level_s2
);

	logic [7:0]  sf_n;
	logic [7:0]  sc_n;
	logic [15:0] fall_full;
	logic [15:0] rise_full;
	logic [7:0]  fall;
	logic [7:0]  rise;
	logic [7:0]  v;
	logic [7:0]  lo;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	// Form the second rank of products and pick channels by mode and sector
	always_comb begin
		// complement at eight bits: 255 minus the value
		sf_n      = ~prod_s1.sf_hi;
		sc_n      = ~prod_s1.sc_hi;
		fall_full = prod_s1.val * sf_n;
		rise_full = prod_s1.val * sc_n;
		fall      = fall_full[15:8];
		rise      = rise_full[15:8];
		v         = prod_s1.val;
		lo        = prod_s1.lo;
		red       = v;
		green     = lo;
		blue      = fall;
		priority if (prod_s1.kind == hsbc_pkg::KIND_DIRECT) begin
			red   = prod_s1.hue;
			green = prod_s1.sat;
			blue  = prod_s1.val;
		end else if (prod_s1.sat == 8'd0) begin
			// grey: every channel takes the brightness
			red   = v;
			green = v;
			blue  = v;
		end else begin
			unique case (prod_s1.sector)
				hsbc_pkg::SECTOR_0: begin
					red = v;    green = rise; blue = lo;
				end
				hsbc_pkg::SECTOR_1: begin
					red = fall; green = v;    blue = lo;
				end
				hsbc_pkg::SECTOR_2: begin
					red = lo;   green = v;    blue = rise;
				end
				hsbc_pkg::SECTOR_3: begin
					red = lo;   green = fall; blue = v;
				end
				hsbc_pkg::SECTOR_4: begin
					red = rise; green = lo;   blue = v;
				end
				default: begin
					red = v;    green = lo;   blue = fall;
				end
			endcase
		end
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			level_s2.pixel <= prod_s1.pixel;
			level_s2.red   <= red;
			level_s2.green <= green;
			level_s2.blue  <= blue;
		end
	end

endmodule

// ----- sv/hsbc_gamma.sv -----
// Third pipeline stage: gamma lookup and inversion into PWM compare values; drives the result.
module hsbc_gamma (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_s2,
	input  hsbc_pkg::level_t   level_s2,
	output logic               valid_s3,
	output hsbc_pkg::compare_t compare_s3
);

	logic [7:0] gr;
	logic [7:0] gg;
	logic [7:0] gb;

	// Look up the gamma curve for each channel
	always_comb begin
		gr = hsbc_pkg::GAMMA[level_s2.red];
		gg = hsbc_pkg::GAMMA[level_s2.green];
		gb = hsbc_pkg::GAMMA[level_s2.blue];
	end

	// Advance the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	// Invert: red and green scale by a quarter, blue by a half
	always_ff @(posedge clk) begin
		if (en) begin
			compare_s3.pixel_out     <= level_s2.pixel;
			compare_s3.red_compare   <= ~{2'b00, gr[7:2]};
			compare_s3.green_compare <= ~{2'b00, gg[7:2]};
			compare_s3.blue_compare  <= ~{1'b0, gb[7:1]};
		end
	end

endmodule

// ----- sv/hsb_to_led_compare_top.sv -----
// Top level of the hue/brightness to LED compare block: stage enables and stage chain.
//
//  channel   payload               handshake               direction
//  color     hsbc_pkg::color_t     color_valid/_stall      in
//  compare   hsbc_pkg::compare_t   compare_valid/_stall    out
//
// One request per cycle sustained while compare is not stalled; each result passes the
// product, channel mix and gamma/output registers in order before it is on compare.
// Reset clears the stage valid bits only; the payload registers are not reset.
// A stall on compare holds the output register; an empty stage still fills,
// so color_stall rises only when all three stages hold requests.
module hsb_to_led_compare_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               color_valid,
	input  hsbc_pkg::color_t   color,
	output logic               color_stall,
	output logic               compare_valid,
	output hsbc_pkg::compare_t compare,
	input  logic               compare_stall
);

	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              en1;
	logic              en2;
	logic              en3;
	hsbc_pkg::prod_t   prod_s1;
	hsbc_pkg::level_t  level_s2;

	// Let a stage load when it is empty or the next one moves
	always_comb begin
		en3         = !valid_s3 || !compare_stall;
		en2         = !valid_s2 || en3;
		en1         = !valid_s1 || en2;
		color_stall = !en1;
	end

	hsbc_prod u_prod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en1),
		.valid    (color_valid),
		.color    (color),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1)
	);

	hsbc_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.prod_s1  (prod_s1),
		.valid_s2 (valid_s2),
		.level_s2 (level_s2)
	);

	hsbc_gamma u_gamma (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en3),
		.valid_s2   (valid_s2),
		.level_s2   (level_s2),
		.valid_s3   (valid_s3),
		.compare_s3 (compare)
	);

	assign compare_valid = valid_s3;

endmodule
